// ===== design/assert_macros.svh =====
// Assertion macros for the core's RTL files; the result queue includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk, disabled while reset is asserted.
`define EBC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same check, held during reset as well.
`define EBC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/ebc_pkg.sv =====
// Shared types, constants and helper functions for the 8-bit CPU core.
`default_nettype none
package ebc_pkg;

	localparam int QDEPTH = 4;
	localparam int QW = $clog2(QDEPTH);
	localparam logic [7:0] HIGH_PAGE = 8'hFF;

	localparam logic CFG_PC_RESET = 1'b0;
	localparam logic CFG_SP_RESET = 1'b1;

	localparam logic BUS_READ = 1'b0;
	localparam logic BUS_WRITE = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_OPC,
		PH_B1,
		PH_B2,
		PH_B3
	} phase_t;

	// Architectural state of the core
	typedef struct packed {
		logic [6:0][7:0] rf;     // B,C,D,E,H,L,A
		logic [3:0]      flags;  // Z N H C
		logic [15:0]     pc;
		logic [15:0]     sp;
		logic [7:0]      opc;
		phase_t          phase;
		logic [7:0]      imm;
	} state_t;

	// One result beat (without the last mark)
	typedef struct packed {
		logic        op;
		logic [15:0] addr;
		logic [7:0]  wdata;
		logic        done;
		logic [2:0]  cyc;
		logic        ill;
	} res_t;

	// Result beat with the last mark, as stored in the output queue
	typedef struct packed {
		res_t res;
		logic last;
	} qent_t;

	function automatic res_t mk_rd(input logic [15:0] addr);
		res_t r;
		r = '0;
		r.op = BUS_READ;
		r.addr = addr;
		return r;
	endfunction

	function automatic res_t mk_wr(input logic [15:0] addr, input logic [7:0] d);
		res_t r;
		r = '0;
		r.op = BUS_WRITE;
		r.addr = addr;
		r.wdata = d;
		return r;
	endfunction

	function automatic res_t mk_fin(input logic [15:0] addr, input logic [2:0] cyc,
			input logic ill);
		res_t r;
		r = '0;
		r.op = BUS_READ;
		r.addr = addr;
		r.done = 1'b1;
		r.cyc = cyc;
		r.ill = ill;
		return r;
	endfunction

	// Register code to file index: A is code 7, code 6 falls back to B
	function automatic logic [2:0] ridx(input logic [2:0] code);
		logic [2:0] r;
		if (code == 3'd7) r = 3'd6;
		else if (code == 3'd6) r = 3'd0;
		else r = code;
		return r;
	endfunction

	// Load immediate to register
	function automatic logic is_ldrn(input logic [7:0] op);
		return (op < 8'h40) && ((op & 8'hC7) == 8'h06) && (op != 8'h36);
	endfunction

	// Jump condition: NZ, Z, NC, C
	function automatic logic cond_ok(input logic [7:0] op, input logic [3:0] flags);
		logic f;
		f = op[4] ? flags[0] : flags[3];
		return op[3] ? f : !f;
	endfunction

	// ADD/ADC/SUB/SBC; returns {flags, result}
	function automatic logic [11:0] alu(input logic [1:0] kind, input logic [7:0] a,
			input logic [7:0] v, input logic cin);
		logic       c;
		logic [8:0] s;
		logic [4:0] hs;
		logic [7:0] r;
		logic       h;
		logic       cy;
		c = kind[0] & cin;
		if (!kind[1]) begin
			s = {1'b0, a} + {1'b0, v} + {8'd0, c};
			hs = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, c};
			h = hs[4];
			cy = s[8];
		end else begin
			s = {1'b0, a} - {1'b0, v} - {8'd0, c};
			hs = {1'b0, v[3:0]} + {4'd0, c};
			h = {1'b0, a[3:0]} < hs;
			cy = {1'b0, a} < ({1'b0, v} + {8'd0, c});
		end
		r = s[7:0];
		return {(r == 8'd0), kind[1], h, cy, r};
	endfunction

endpackage
`default_nettype wire

// ===== design/ebc_step.sv =====
// Instruction step logic: next state and bus beats for one input item.
`default_nettype none
module ebc_step (
	input  var ebc_pkg::state_t st,
	input  wire                 action,
	input  wire [7:0]           read_data,
	output ebc_pkg::state_t     ns,
	output logic [1:0]          n,
	output ebc_pkg::res_t       r0,
	output ebc_pkg::res_t       r1,
	output ebc_pkg::res_t       r2
);

	logic [7:0]  op;
	logic [7:0]  b;
	logic [15:0] hl;
	logic [15:0] ad;
	logic [2:0]  pi;
	logic [11:0] au;
	logic [7:0]  hi;
	logic [7:0]  lo;

	always_comb begin
		ns = st;
		n = 2'd0;
		r0 = '0;
		r1 = '0;
		r2 = '0;
		b = read_data;
		hl = {st.rf[4], st.rf[5]};
		ad = {b, st.imm};
		op = (st.phase == ebc_pkg::PH_OPC) ? b : st.opc;
		pi = {op[5:4], 1'b0};
		au = ebc_pkg::alu(op[4:3], st.rf[6], b, st.flags[0]);
		hi = '0;
		lo = '0;
		if (!action) begin
			// kick: first opcode fetch
			if (st.phase == ebc_pkg::PH_IDLE) begin
				r0 = ebc_pkg::mk_rd(st.pc);
				ns.pc = st.pc + 16'd1;
				ns.phase = ebc_pkg::PH_OPC;
				n = 2'd1;
			end
		end else begin
			unique case (st.phase)
			ebc_pkg::PH_OPC: begin
				ns.opc = op;
				if (ebc_pkg::is_ldrn(op)) begin
					r0 = ebc_pkg::mk_rd(st.pc);
					ns.pc = st.pc + 16'd1;
					ns.phase = ebc_pkg::PH_B1;
					n = 2'd1;
				end else if (op >= 8'h40 && op <= 8'h7F && op != 8'h76) begin
					if (op[2:0] == 3'd6) begin
						r0 = ebc_pkg::mk_rd(hl);
						ns.phase = ebc_pkg::PH_B1;
						n = 2'd1;
					end else if (op[5:3] == 3'd6) begin
						r0 = ebc_pkg::mk_wr(hl, st.rf[ebc_pkg::ridx(op[2:0])]);
						r1 = ebc_pkg::mk_fin(st.pc, 3'd2, 1'b0);
						ns.pc = st.pc + 16'd1;
						ns.phase = ebc_pkg::PH_OPC;
						n = 2'd2;
					end else begin
						ns.rf[ebc_pkg::ridx(op[5:3])] = st.rf[ebc_pkg::ridx(op[2:0])];
						r0 = ebc_pkg::mk_fin(st.pc, 3'd1, 1'b0);
						ns.pc = st.pc + 16'd1;
						n = 2'd1;
					end
				end else if (op >= 8'h80 && op <= 8'h9F) begin
					if (op[2:0] == 3'd6) begin
						r0 = ebc_pkg::mk_rd(hl);
						ns.phase = ebc_pkg::PH_B1;
						n = 2'd1;
					end else begin
						au = ebc_pkg::alu(op[4:3], st.rf[6], st.rf[ebc_pkg::ridx(op[2:0])],
							st.flags[0]);
						ns.flags = au[11:8];
						ns.rf[6] = au[7:0];
						r0 = ebc_pkg::mk_fin(st.pc, 3'd1, 1'b0);
						ns.pc = st.pc + 16'd1;
						n = 2'd1;
					end
				end else begin
					// default: completes at once with one result, unless an arm below overrides it
					r0 = ebc_pkg::mk_fin(st.pc, 3'd1, 1'b0);
					ns.pc = st.pc + 16'd1;
					n = 2'd1;
					case (op)
					8'h00: ;
					8'h01, 8'h11, 8'h21, 8'h31, 8'h08, 8'h36,
					8'hC2, 8'hC3, 8'hCA, 8'hD2, 8'hDA,
					8'hC6, 8'hCE, 8'hD6, 8'hDE,
					8'hE0, 8'hF0, 8'hEA, 8'hFA: begin
						r0 = ebc_pkg::mk_rd(st.pc);
						ns.phase = ebc_pkg::PH_B1;
					end
					8'h02, 8'h12: begin
						r0 = ebc_pkg::mk_wr(op[4] ? {st.rf[2], st.rf[3]}
							: {st.rf[0], st.rf[1]}, st.rf[6]);
						r1 = ebc_pkg::mk_fin(st.pc, 3'd2, 1'b0);
						n = 2'd2;
					end
					8'h0A, 8'h1A: begin
						r0 = ebc_pkg::mk_rd(op[4] ? {st.rf[2], st.rf[3]}
							: {st.rf[0], st.rf[1]});
						ns.pc = st.pc;
						ns.phase = ebc_pkg::PH_B1;
					end
					8'h22, 8'h32: begin
						r0 = ebc_pkg::mk_wr(hl, st.rf[6]);
						{ns.rf[4], ns.rf[5]} = op[4] ? hl - 16'd1 : hl + 16'd1;
						r1 = ebc_pkg::mk_fin(st.pc, 3'd2, 1'b0);
						n = 2'd2;
					end
					8'h2A, 8'h3A: begin
						r0 = ebc_pkg::mk_rd(hl);
						{ns.rf[4], ns.rf[5]} = op[4] ? hl - 16'd1 : hl + 16'd1;
						ns.pc = st.pc;
						ns.phase = ebc_pkg::PH_B1;
					end
					8'hBE: begin
						r0 = ebc_pkg::mk_rd(hl);
						ns.pc = st.pc;
						ns.phase = ebc_pkg::PH_B1;
					end
					8'hC1, 8'hD1, 8'hE1, 8'hF1: begin
						r0 = ebc_pkg::mk_rd(st.sp);
						ns.sp = st.sp + 16'd1;
						ns.pc = st.pc;
						ns.phase = ebc_pkg::PH_B1;
					end
					8'hC5, 8'hD5, 8'hE5, 8'hF5: begin
						hi = (op[5:4] == 2'd3) ? st.rf[6] : st.rf[pi];
						lo = (op[5:4] == 2'd3) ? {st.flags, 4'd0} : st.rf[pi + 3'd1];
						r0 = ebc_pkg::mk_wr(st.sp - 16'd1, hi);
						r1 = ebc_pkg::mk_wr(st.sp - 16'd2, lo);
						r2 = ebc_pkg::mk_fin(st.pc, 3'd4, 1'b0);
						ns.sp = st.sp - 16'd2;
						n = 2'd3;
					end
					8'hE2: begin
						r0 = ebc_pkg::mk_wr({ebc_pkg::HIGH_PAGE, st.rf[1]}, st.rf[6]);
						r1 = ebc_pkg::mk_fin(st.pc, 3'd2, 1'b0);
						n = 2'd2;
					end
					8'hF2: begin
						r0 = ebc_pkg::mk_rd({ebc_pkg::HIGH_PAGE, st.rf[1]});
						ns.pc = st.pc;
						ns.phase = ebc_pkg::PH_B1;
					end
					8'hE9: begin
						r0 = ebc_pkg::mk_fin(hl, 3'd1, 1'b0);
						ns.pc = hl + 16'd1;
					end
					8'hF9: begin
						ns.sp = hl;
						r0 = ebc_pkg::mk_fin(st.pc, 3'd2, 1'b0);
					end
					default: r0 = ebc_pkg::mk_fin(st.pc, 3'd1, 1'b1);
					endcase
				end
			end
			ebc_pkg::PH_B1: begin
				// most arms finish: set the common fetch up front
				r0 = ebc_pkg::mk_fin(st.pc, 3'd2, 1'b0);
				ns.pc = st.pc + 16'd1;
				ns.phase = ebc_pkg::PH_OPC;
				n = 2'd1;
				if (ebc_pkg::is_ldrn(op) || (op >= 8'h40 && op <= 8'h7F)) begin
					ns.rf[ebc_pkg::ridx(op[5:3])] = b;
				end else if ((op >= 8'h80 && op <= 8'h9F) || op == 8'hC6 || op == 8'hCE
						|| op == 8'hD6 || op == 8'hDE) begin
					ns.flags = au[11:8];
					ns.rf[6] = au[7:0];
				end else begin
					case (op)
					8'h01, 8'h11, 8'h21, 8'h31, 8'h08,
					8'hC2, 8'hC3, 8'hCA, 8'hD2, 8'hDA, 8'hEA, 8'hFA: begin
						ns.imm = b;
						r0 = ebc_pkg::mk_rd(st.pc);
						ns.phase = ebc_pkg::PH_B2;
					end
					8'h0A, 8'h1A, 8'h2A, 8'h3A, 8'hF2: ns.rf[6] = b;
					8'h36: begin
						r0 = ebc_pkg::mk_wr(hl, b);
						r1 = ebc_pkg::mk_fin(st.pc, 3'd3, 1'b0);
						n = 2'd2;
					end
					8'hBE: ns.flags = {(st.rf[6] == b), 1'b1, (st.rf[6][3:0] < b[3:0]),
						(st.rf[6] < b)};
					8'hC1, 8'hD1, 8'hE1, 8'hF1: begin
						ns.imm = b;
						r0 = ebc_pkg::mk_rd(st.sp);
						ns.sp = st.sp + 16'd1;
						ns.pc = st.pc;
						ns.phase = ebc_pkg::PH_B2;
					end
					8'hE0: begin
						r0 = ebc_pkg::mk_wr({ebc_pkg::HIGH_PAGE, b}, st.rf[6]);
						r1 = ebc_pkg::mk_fin(st.pc, 3'd3, 1'b0);
						n = 2'd2;
					end
					8'hF0: begin
						r0 = ebc_pkg::mk_rd({ebc_pkg::HIGH_PAGE, b});
						ns.pc = st.pc;
						ns.phase = ebc_pkg::PH_B3;
					end
					default: r0 = ebc_pkg::mk_fin(st.pc, 3'd1, 1'b1);
					endcase
				end
			end
			ebc_pkg::PH_B2: begin
				r0 = ebc_pkg::mk_fin(st.pc, 3'd3, 1'b0);
				ns.pc = st.pc + 16'd1;
				ns.phase = ebc_pkg::PH_OPC;
				n = 2'd1;
				case (op)
				8'h01, 8'h11, 8'h21, 8'hC1, 8'hD1, 8'hE1: begin
					ns.rf[pi] = b;
					ns.rf[pi + 3'd1] = st.imm;
				end
				8'h31: ns.sp = ad;
				8'h08: begin
					r0 = ebc_pkg::mk_wr(ad, st.sp[7:0]);
					r1 = ebc_pkg::mk_wr(ad + 16'd1, st.sp[15:8]);
					r2 = ebc_pkg::mk_fin(st.pc, 3'd5, 1'b0);
					n = 2'd3;
				end
				8'hC3: begin
					r0 = ebc_pkg::mk_fin(ad, 3'd4, 1'b0);
					ns.pc = ad + 16'd1;
				end
				8'hC2, 8'hCA, 8'hD2, 8'hDA: begin
					if (ebc_pkg::cond_ok(op, st.flags)) begin
						r0 = ebc_pkg::mk_fin(ad, 3'd4, 1'b0);
						ns.pc = ad + 16'd1;
					end
				end
				8'hEA: begin
					r0 = ebc_pkg::mk_wr(ad, st.rf[6]);
					r1 = ebc_pkg::mk_fin(st.pc, 3'd4, 1'b0);
					n = 2'd2;
				end
				8'hFA: begin
					r0 = ebc_pkg::mk_rd(ad);
					ns.pc = st.pc;
					ns.phase = ebc_pkg::PH_B3;
				end
				8'hF1: begin
					ns.rf[6] = b;
					ns.flags = st.imm[7:4];
				end
				default: r0 = ebc_pkg::mk_fin(st.pc, 3'd1, 1'b1);
				endcase
			end
			ebc_pkg::PH_B3: begin
				ns.rf[6] = b;
				if (op == 8'hFA) r0 = ebc_pkg::mk_fin(st.pc, 3'd4, 1'b0);
				else if (op == 8'hF0) r0 = ebc_pkg::mk_fin(st.pc, 3'd3, 1'b0);
				else r0 = ebc_pkg::mk_fin(st.pc, 3'd1, 1'b1);
				ns.pc = st.pc + 16'd1;
				ns.phase = ebc_pkg::PH_OPC;
				n = 2'd1;
			end
			default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/ebc_fifo.sv =====
// Result queue: takes up to three beats per cycle, hands out one per cycle unless out_stall holds it.
`default_nettype none
`include "assert_macros.svh"
module ebc_fifo (
	input  wire                clk,
	input  wire                arst_n,
	input  wire  [1:0]         wr_n,
	input  var ebc_pkg::res_t  w0,
	input  var ebc_pkg::res_t  w1,
	input  var ebc_pkg::res_t  w2,
	output logic               room,
	output logic               out_valid,
	input  wire                out_stall,
	output ebc_pkg::qent_t     head
);

	ebc_pkg::qent_t             mem_q [ebc_pkg::QDEPTH];
	logic [ebc_pkg::QW-1:0]     wp_q;
	logic [ebc_pkg::QW-1:0]     rp_q;
	logic [ebc_pkg::QW:0]       count_q;
	logic                       rd_en;

	assign out_valid = (count_q != '0);
	assign rd_en = out_valid && !out_stall;
	assign room = (count_q <= (ebc_pkg::QW+1)'(ebc_pkg::QDEPTH - 3));
	assign head = mem_q[rp_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			count_q <= '0;
		end else begin
			wp_q <= wp_q + ebc_pkg::QW'(wr_n);
			if (rd_en) rp_q <= rp_q + 1'b1;
			count_q <= count_q + (ebc_pkg::QW+1)'(wr_n) - (ebc_pkg::QW+1)'(rd_en);
		end
	end

	// beat storage; the last beat of a burst carries the mark
	always_ff @(posedge clk) begin
		if (wr_n != 2'd0) mem_q[wp_q] <= '{res: w0, last: (wr_n == 2'd1)};
		if (wr_n >= 2'd2) mem_q[wp_q + 1'b1] <= '{res: w1, last: (wr_n == 2'd2)};
		if (wr_n == 2'd3) mem_q[wp_q + 2'd2] <= '{res: w2, last: 1'b1};
	end

	`EBC_ASSERT(a_no_overflow, count_q <= (ebc_pkg::QW+1)'(ebc_pkg::QDEPTH), "queue overflow")
	`EBC_ASSERT(a_hold, out_valid && out_stall && wr_n == 2'd0 |=> $stable(count_q), "count moved")
	`EBC_ASSERT(a_drain, rd_en && count_q == 1 && wr_n == 2'd0 |=> !out_valid, "queue not empty")

endmodule
`default_nettype wire

// ===== design/eight_bit_cpu_load_alu_jump_core.sv =====
// Latency: an accepted item's beats are in the result queue the next cycle.
// Throughput: one item per cycle while results drain one beat per cycle.
// Items causing two or three beats are limited by the single output beat per cycle.
// Input is accepted while the four-entry result queue holds at most one beat.
// Reset clears registers and flags, loads pc with 0x0100 and sp with 0xFFFE.
`default_nettype none
module eight_bit_cpu_load_alu_jump_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire         action,
	input  wire  [7:0]  read_data,
	output logic        out_valid,
	input  wire         out_stall,
	output logic        bus_op,
	output logic [15:0] bus_addr,
	output logic [7:0]  write_data,
	output logic        instr_done,
	output logic [2:0]  instr_cycles,
	output logic        illegal,
	output logic        last
);

	ebc_pkg::state_t st_q;
	ebc_pkg::state_t ns;
	logic [15:0]     pc_reset_q;
	logic [15:0]     sp_reset_q;
	logic [1:0]      n;
	ebc_pkg::res_t   r0;
	ebc_pkg::res_t   r1;
	ebc_pkg::res_t   r2;
	logic            room;
	logic            acc;
	logic            cfg_wr;
	ebc_pkg::qent_t  head;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = {16'd0, (paddr[2] == ebc_pkg::CFG_SP_RESET) ? sp_reset_q : pc_reset_q};
	assign in_stall = !room;
	assign acc = in_valid && room;

	ebc_step u_step (
		.st(st_q), .action(action), .read_data(read_data),
		.ns(ns), .n(n), .r0(r0), .r1(r1), .r2(r2)
	);

	ebc_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .wr_n(acc ? n : 2'd0),
		.w0(r0), .w1(r1), .w2(r2), .room(room),
		.out_valid(out_valid), .out_stall(out_stall), .head(head)
	);

	// reset-value registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_reset_q <= 16'h0100;
			sp_reset_q <= 16'hFFFE;
		end else if (cfg_wr) begin
			if (paddr[2] == ebc_pkg::CFG_PC_RESET) pc_reset_q <= pwdata[15:0];
			else sp_reset_q <= pwdata[15:0];
		end
	end

	// core state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{rf: '0, flags: '0, pc: 16'h0100, sp: 16'hFFFE, opc: '0,
				phase: ebc_pkg::PH_IDLE, imm: '0};
		end else if (acc) begin
			st_q <= ns;
		end else if (cfg_wr && st_q.phase == ebc_pkg::PH_IDLE) begin
			if (paddr[2] == ebc_pkg::CFG_PC_RESET) st_q.pc <= pwdata[15:0];
			else st_q.sp <= pwdata[15:0];
		end
	end

	assign bus_op = head.res.op;
	assign bus_addr = head.res.addr;
	assign write_data = head.res.wdata;
	assign instr_done = head.res.done;
	assign instr_cycles = head.res.cyc;
	assign illegal = head.res.ill;
	assign last = head.last;

endmodule
`default_nettype wire
